FILE: src/kcd_pkg.sv
// Shared types and reset constants for the key click and double-click detector.
package kcd_pkg;

   localparam int unsigned DebounceWidth = 4;
   localparam int unsigned IdleWidth     = 8;
   localparam int unsigned CsrIndexWidth = 2;
   localparam int unsigned CsrDataWidth  = 8;

   localparam logic [DebounceWidth-1:0] DebounceTicksReset = 4'd5;
   localparam logic [IdleWidth-1:0]     DoubleWindowReset  = 8'd20;
   localparam logic [IdleWidth-1:0]     ClickDelayReset    = 8'd25;
   localparam logic [IdleWidth-1:0]     IdleMax            = 8'd255;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_DEBOUNCE_TICKS = 2'd0,
      CSR_DOUBLE_WINDOW  = 2'd1,
      CSR_CLICK_DELAY    = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic key_pressed;
      logic lockout;
      logic idle_preset;
   } req_payload_type;

   typedef struct packed {
      logic click;
      logic double_click;
      logic debounced_level;
   } rsp_payload_type;

endpackage

FILE: src/kcd_if.sv
// Valid/ready channel interfaces for the detector's tick and result transactions.
interface kcd_req_if;
   logic valid;
   logic ready;
   logic key_pressed;
   logic lockout;
   logic idle_preset;

   modport source (output valid, output key_pressed, output lockout, output idle_preset,
                   input ready);
   modport sink (input valid, input key_pressed, input lockout, input idle_preset,
                 output ready);
endinterface

interface kcd_rsp_if;
   logic valid;
   logic ready;
   logic click;
   logic double_click;
   logic debounced_level;

   modport source (output valid, output click, output double_click,
                   output debounced_level, input ready);
   modport sink (input valid, input click, input double_click, input debounced_level,
                 output ready);
endinterface

FILE: src/key_click_double_click_detector.sv
// Top level of the key click and double-click detector with debounce.
//
// The block takes one transaction per sampling tick and returns one result per tick, at a
// sustained rate of one transaction per cycle while results are taken: all the debounce,
// idle counting and click decisions are small compares on the state registers, done in the
// accepting cycle and captured in the output register or the skid register. A two-entry
// output stage (output register plus skid register) lets the input side take one more
// transaction while a result waits. After that the input stalls until the waiting result
// is taken, and input ready comes straight from a register.
module key_click_double_click_detector (
   input  logic                                 clock,
   input  logic                                 reset,
   kcd_req_if.sink                              req_chan,
   kcd_rsp_if.source                            rsp_chan,
   input  logic                                 csr_write_enable,
   input  logic [kcd_pkg::CsrIndexWidth-1:0]    csr_index,
   input  logic [kcd_pkg::CsrDataWidth-1:0]     csr_write_data
);
   import kcd_pkg::*;

   logic [DebounceWidth-1:0] debounce_ticks_ff;
   logic [IdleWidth-1:0]     double_window_ff;
   logic [IdleWidth-1:0]     click_delay_ff;

   logic                     last_raw_ff, last_raw_in;
   logic [DebounceWidth-1:0] stable_count_ff, stable_count_in;
   logic                     accepted_level_ff, accepted_level_in;
   logic                     release_pending_ff, release_pending_in;
   logic                     double_active_ff, double_active_in;
   logic [IdleWidth-1:0]     idle_count_ff, idle_count_in;
   logic [IdleWidth-1:0]     idle_start;

   rsp_payload_type          result;
   rsp_payload_type          out_data_ff, out_data_in;
   rsp_payload_type          skid_data_ff, skid_data_in;
   logic                     out_valid_ff, out_valid_in;
   logic                     skid_valid_ff, skid_valid_in;
   logic                     req_accept;
   logic                     rsp_take;

   assign req_chan.ready = !skid_valid_ff;
   assign req_accept     = req_chan.valid && !skid_valid_ff;
   assign rsp_take       = out_valid_ff && rsp_chan.ready;

   assign rsp_chan.valid           = out_valid_ff;
   assign rsp_chan.click           = out_data_ff.click;
   assign rsp_chan.double_click    = out_data_ff.double_click;
   assign rsp_chan.debounced_level = out_data_ff.debounced_level;

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ticks_ff <= DebounceTicksReset;
         double_window_ff  <= DoubleWindowReset;
         click_delay_ff    <= ClickDelayReset;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_DEBOUNCE_TICKS: debounce_ticks_ff <= csr_write_data[DebounceWidth-1:0];
            CSR_DOUBLE_WINDOW:  double_window_ff  <= csr_write_data[IdleWidth-1:0];
            CSR_CLICK_DELAY:    click_delay_ff    <= csr_write_data[IdleWidth-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      idle_start         = req_chan.idle_preset ? IdleMax : idle_count_ff;
      last_raw_in        = last_raw_ff;
      stable_count_in    = stable_count_ff;
      accepted_level_in  = accepted_level_ff;
      release_pending_in = release_pending_ff;
      double_active_in   = double_active_ff;
      idle_count_in      = idle_start;
      result             = '0;

      if (req_chan.lockout) begin
         stable_count_in = '0;
      end else begin
         if (req_chan.key_pressed != last_raw_ff) begin
            stable_count_in = '0;
            last_raw_in     = req_chan.key_pressed;
         end else if (stable_count_ff < debounce_ticks_ff) begin
            stable_count_in = stable_count_ff + DebounceWidth'(1);
         end else if (last_raw_ff != accepted_level_ff) begin
            accepted_level_in  = last_raw_ff;
            release_pending_in = 1'b0;
            if (last_raw_ff) begin
               if (idle_start < double_window_ff) begin
                  result.double_click = 1'b1;
                  double_active_in    = 1'b1;
               end else begin
                  double_active_in = 1'b0;
               end
            end else begin
               if (!double_active_ff) begin
                  release_pending_in = 1'b1;
               end
               idle_count_in = '0;
            end
         end

         if (!accepted_level_in) begin
            if (idle_count_in != IdleMax) begin
               idle_count_in = idle_count_in + IdleWidth'(1);
            end
            if (release_pending_in && (idle_count_in > click_delay_ff)) begin
               release_pending_in = 1'b0;
               result.click       = 1'b1;
            end
         end
      end
      result.debounced_level = accepted_level_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_raw_ff        <= 1'b0;
         stable_count_ff    <= '0;
         accepted_level_ff  <= 1'b0;
         release_pending_ff <= 1'b0;
         double_active_ff   <= 1'b0;
         idle_count_ff      <= IdleMax;
      end else if (req_accept) begin
         last_raw_ff        <= last_raw_in;
         stable_count_ff    <= stable_count_in;
         accepted_level_ff  <= accepted_level_in;
         release_pending_ff <= release_pending_in;
         double_active_ff   <= double_active_in;
         idle_count_ff      <= idle_count_in;
      end
   end

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || rsp_take) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = req_accept;
            out_data_in  = result;
         end
      end else if (req_accept) begin
         skid_valid_in = 1'b1;
         skid_data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

endmodule

FILE: src/kcd_checker.sv
// Port-level assertions for the detector and the bind that attaches them.
module kcd_checker (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_click,
   input logic rsp_double_click,
   input logic rsp_debounced_level
);

   // A result never reports both kinds of click at once.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_click && rsp_double_click))
      else $error("click and double click in the same transaction");

   // A double click is reported only with the key held pressed.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_double_click) |-> rsp_debounced_level)
      else $error("double click while the key is released");

   // A single click is reported only with the key released.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_click) |-> !rsp_debounced_level)
      else $error("single click while the key is pressed");

   // A stalled result holds its contents.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_click)
         && $stable(rsp_double_click) && $stable(rsp_debounced_level)))
      else $error("stalled result transaction changed");

endmodule

bind key_click_double_click_detector kcd_checker u_kcd_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_chan.valid),
   .rsp_ready           (rsp_chan.ready),
   .rsp_click           (rsp_chan.click),
   .rsp_double_click    (rsp_chan.double_click),
   .rsp_debounced_level (rsp_chan.debounced_level)
);

FILE: tb/tb_key_click_double_click_detector.sv
// Self-checking testbench for the key click and double-click detector.
`timescale 1ns / 100ps

module tb_key_click_double_click_detector;
   import kcd_pkg::*;

   localparam logic [CsrIndexWidth-1:0] CsrIndexSpare = 2'd3;
   localparam int unsigned CycleLimit  = 250000;
   localparam int unsigned PhaseTicks  = 260;
   localparam int unsigned HoldCycles  = 60;
   localparam int unsigned MaxReports  = 100;

   class click_scoreboard;
      bit [DebounceWidth-1:0] debounce_ticks;
      bit [IdleWidth-1:0]     double_window;
      bit [IdleWidth-1:0]     click_delay;
      bit                     last_raw;
      bit [DebounceWidth-1:0] stable_count;
      bit                     accepted_level;
      bit                     release_pending;
      bit                     double_active;
      bit [IdleWidth-1:0]     idle_count;
      rsp_payload_type        key_outcomes[$];
      int unsigned            errors;

      function new();
         debounce_ticks  = DebounceTicksReset;
         double_window   = DoubleWindowReset;
         click_delay     = ClickDelayReset;
         last_raw        = 1'b0;
         stable_count    = '0;
         accepted_level  = 1'b0;
         release_pending = 1'b0;
         double_active   = 1'b0;
         idle_count      = IdleMax;
         errors          = 0;
      endfunction

      function void write_register(logic [CsrIndexWidth-1:0] index,
                                   logic [CsrDataWidth-1:0] data);
         case (csr_index_type'(index))
            CSR_DEBOUNCE_TICKS: debounce_ticks = data[DebounceWidth-1:0];
            CSR_DOUBLE_WINDOW:  double_window = data;
            CSR_CLICK_DELAY:    click_delay = data;
            default: ;
         endcase
      endfunction

      function void advance_key_state(req_payload_type tick);
         rsp_payload_type outcome;
         outcome = '0;
         if (tick.idle_preset) idle_count = IdleMax;
         if (tick.lockout) begin
            stable_count = '0;
         end else begin
            if (tick.key_pressed != last_raw) begin
               stable_count = '0;
               last_raw = tick.key_pressed;
            end else if (stable_count < debounce_ticks) begin
               stable_count = stable_count + 1'b1;
            end else if (last_raw != accepted_level) begin
               accepted_level = last_raw;
               release_pending = 1'b0;
               if (accepted_level) begin
                  if (idle_count < double_window) begin
                     outcome.double_click = 1'b1;
                     double_active = 1'b1;
                  end else begin
                     double_active = 1'b0;
                  end
               end else begin
                  if (!double_active) release_pending = 1'b1;
                  idle_count = '0;
               end
            end
            if (!accepted_level) begin
               if (idle_count < IdleMax) idle_count = idle_count + 1'b1;
               if (release_pending && idle_count > click_delay) begin
                  release_pending = 1'b0;
                  outcome.click = 1'b1;
               end
            end
         end
         outcome.debounced_level = accepted_level;
         key_outcomes.push_back(outcome);
      endfunction

      task report(string what);
         if (errors < MaxReports) $display("[%0t] mismatch: %s", $time, what);
         errors++;
      endtask

      task check_outcome(rsp_payload_type seen);
         rsp_payload_type want;
         if (key_outcomes.size() == 0) begin
            report($sformatf("result %b with no transaction outstanding", seen));
         end else begin
            want = key_outcomes.pop_front();
            if (seen.click !== want.click)
               report($sformatf("click %b, expected %b", seen.click, want.click));
            if (seen.double_click !== want.double_click)
               report($sformatf("double_click %b, expected %b", seen.double_click,
                                want.double_click));
            if (seen.debounced_level !== want.debounced_level)
               report($sformatf("debounced_level %b, expected %b", seen.debounced_level,
                                want.debounced_level));
         end
      endtask
   endclass

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic [CsrIndexWidth-1:0] csr_index;
   logic [CsrDataWidth-1:0]  csr_write_data;

   kcd_req_if req_chan ();
   kcd_rsp_if rsp_chan ();

   click_scoreboard sb;
   bit steady_flow;
   int unsigned results_seen;
   int unsigned cycle_count;

   key_click_double_click_detector i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   always @(posedge clock) begin : monitor
      req_payload_type tick;
      rsp_payload_type seen;
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            tick.key_pressed = req_chan.key_pressed;
            tick.lockout     = req_chan.lockout;
            tick.idle_preset = req_chan.idle_preset;
            sb.advance_key_state(tick);
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            seen.click           = rsp_chan.click;
            seen.double_click    = rsp_chan.double_click;
            seen.debounced_level = rsp_chan.debounced_level;
            sb.check_outcome(seen);
            results_seen++;
         end
      end
   end

   initial begin : result_sink
      int unsigned hold_left;
      int unsigned next_hold_at;
      hold_left = 0;
      next_hold_at = 400;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_chan.ready <= 1'b0;
            hold_left--;
         end else if (!reset && results_seen >= next_hold_at) begin
            rsp_chan.ready <= 1'b0;
            hold_left = HoldCycles - 1;
            next_hold_at += 700;
         end else begin
            rsp_chan.ready <= steady_flow || ($urandom_range(0, 99) >= 32);
         end
      end
   end

   task automatic send_tick(req_payload_type tick);
      while (!steady_flow && $urandom_range(0, 99) < 32) begin
         @(negedge clock);
         req_chan.valid       <= 1'b0;
         req_chan.key_pressed <= 1'($urandom);
         req_chan.lockout     <= 1'($urandom);
         req_chan.idle_preset <= 1'($urandom);
      end
      @(negedge clock);
      req_chan.valid       <= 1'b1;
      req_chan.key_pressed <= tick.key_pressed;
      req_chan.lockout     <= tick.lockout;
      req_chan.idle_preset <= tick.idle_preset;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (sb.key_outcomes.size() != 0) @(negedge clock);
   endtask

   task automatic write_csr(logic [CsrIndexWidth-1:0] index, logic [CsrDataWidth-1:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= data;
      sb.write_register(index, data);
   endtask

   task automatic configure(logic [DebounceWidth-1:0] debounce, logic [IdleWidth-1:0] window,
                            logic [IdleWidth-1:0] delay);
      write_csr(CSR_DEBOUNCE_TICKS, {4'($urandom), debounce});
      write_csr(CSR_DOUBLE_WINDOW, window);
      write_csr(CSR_CLICK_DELAY, delay);
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic run_directed();
      bit [2:0] plan [0:22] = '{3'b000, 3'b001, 3'b010, 3'b011, 3'b100, 3'b101, 3'b110,
                                3'b111, 3'b000, 3'b000, 3'b100, 3'b100, 3'b000, 3'b000,
                                3'b010, 3'b000, 3'b101, 3'b100, 3'b000, 3'b000, 3'b000,
                                3'b000, 3'b000};
      foreach (plan[i]) send_tick(req_payload_type'(plan[i]));
   endtask

   task automatic run_key_sequences(int unsigned count);
      req_payload_type tick;
      bit level;
      int unsigned run_left;
      int unsigned db;
      int unsigned win;
      int unsigned dly;
      level = 1'b0;
      run_left = 0;
      db  = sb.debounce_ticks;
      win = sb.double_window;
      dly = sb.click_delay;
      for (int unsigned i = 0; i < count; i++) begin
         if (run_left == 0) begin
            level = ~level;
            case ($urandom_range(0, 7))
               0:       run_left = $urandom_range(1, db + 1);
               1, 2, 3: run_left = db + 2 + $urandom_range(0, 4);
               4, 5:    run_left = db + 2 + $urandom_range(0, win + 2);
               6:       run_left = db + 2 + $urandom_range(0, dly + 8);
               default: run_left = $urandom_range(200, 270);
            endcase
         end
         run_left--;
         tick.key_pressed = level ^ ($urandom_range(0, 99) < 6);
         tick.lockout     = $urandom_range(0, 99) < 4;
         tick.idle_preset = $urandom_range(0, 99) < 3;
         send_tick(tick);
      end
   endtask

   initial begin : stimulus
      sb = new();
      steady_flow          = 1'b0;
      results_seen         = 0;
      cycle_count          = 0;
      reset                = 1'b1;
      csr_write_enable     = 1'b0;
      csr_index            = '0;
      csr_write_data       = '0;
      req_chan.valid       = 1'b0;
      req_chan.key_pressed = 1'b0;
      req_chan.lockout     = 1'b0;
      req_chan.idle_preset = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      write_csr(CsrIndexSpare, 8'hff);
      configure(4'd0, 8'd8, 8'd2);
      run_directed();
      wait_drained();

      for (int phase = 0; phase < 7; phase++) begin
         case (phase)
            0:       configure(DebounceTicksReset, DoubleWindowReset, ClickDelayReset);
            1:       configure(4'd0, 8'd0, 8'd0);
            2:       configure(4'd15, 8'd255, 8'd255);
            3:       configure(4'd15, 8'd255, 8'd254);
            default: configure(4'($urandom), 8'($urandom), 8'($urandom));
         endcase
         steady_flow = (phase == 3);
         if (phase == 1) begin
            run_key_sequences(PhaseTicks / 2);
            wait_drained();
            run_key_sequences(PhaseTicks / 2);
         end else begin
            run_key_sequences(PhaseTicks);
         end
         wait_drained();
         steady_flow = 1'b0;
      end

      repeat (4) @(posedge clock);
      if (sb.errors == 0 && sb.key_outcomes.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
